### hw/rtl/prrp_pkg.sv
// shared types, constants and register codes for the ring read planner
`timescale 1ns / 1ps

package prrp_pkg;

    // default parameter values
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int NUM_BLOCKS_DEF = 256;

    // field and internal widths
    localparam int RLEN_W  = 17;
    localparam int MAXC_W  = 16;
    localparam int RPB_W   = 31;
    localparam int RING_W  = 41;
    localparam int OFS_W   = 48;
    localparam int CALC_W  = 50;
    localparam int CNT_W   = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    // reset values of the configuration registers
    localparam logic [RLEN_W-1:0] RLEN_RST = RLEN_W'(64);
    localparam logic [MAXC_W-1:0] MAXC_RST = MAXC_W'(1024);
    localparam logic [RPB_W-1:0]  RPB_RST  = RPB_W'(65536);
    localparam logic [RING_W-1:0] RING_RST = RING_W'(16777216);

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_RECORD_LENGTH     = 2'd0,
        REG_MAX_CHUNK_RECORDS = 2'd1,
        REG_RECORDS_PER_BLOCK = 2'd2,
        REG_RING_SIZE         = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  block_index;
        logic [30:0] records_wanted;
    } t_req;

    typedef struct packed {
        logic [31:0] entry_id;
        logic [47:0] seek_record;
        logic [15:0] chunk_records;
        logic [47:0] ring_start_aligned;
        logic [47:0] data_start;
        logic [47:0] data_end;
        logic [47:0] ring_end_aligned;
        logic        overflow;
    } t_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_BLK,
        S_RD,
        S_LOAD,
        S_HEAD,
        S_DIV,
        S_TAIL,
        S_GAP2,
        S_PMOD,
        S_FIT,
        S_CAP,
        S_CNT,
        S_MUL,
        S_DS,
        S_DE,
        S_EA,
        S_OUT
    } t_state;

endpackage

### hw/rtl/prrp_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface prrp_req_if;
    logic            valid;
    logic            ready;
    prrp_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface prrp_rsp_if;
    logic            valid;
    logic            ready;
    prrp_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/page_aligned_ring_read_planner_top.sv
// ring read planner: block table in memory, shared serial divider, descriptor output
// each request runs two divisions on the shared divider: ring base by wrap, then fit by record length
// a page gap adds a division per page, a skip to the next wrap one or two more
// one request at a time; a stalled output holds it
// block index reduction subtracts NUM_BLOCKS until the index is below it
// reset: synchronous active low; then a clearing pass over the whole
// block table, during which no request is taken (configuration writes are)
`timescale 1ns / 1ps

module page_aligned_ring_read_planner_top #(
    parameter int PAGE_BYTES = prrp_pkg::PAGE_BYTES_DEF,
    parameter int NUM_BLOCKS = prrp_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prrp_req_if.sink                      i_req,
    prrp_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prrp_pkg::PADDR_W-1:0]  paddr,
    input  logic [prrp_pkg::PDATA_W-1:0]  pwdata,
    output logic [prrp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int PG_W  = $clog2(PAGE_BYTES);
    localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW    = prrp_pkg::CALC_W;
    localparam int RW    = prrp_pkg::RING_W;
    localparam int DCNT_W = $clog2(CW);
    localparam logic [CW-1:0]   PAGE_C = CW'(PAGE_BYTES);
    localparam logic [PG_W-1:0] PG_MASK = {PG_W{1'b1}};

    // configuration registers
    logic [prrp_pkg::RLEN_W-1:0] r_rlen;
    logic [prrp_pkg::MAXC_W-1:0] r_maxc;
    logic [prrp_pkg::RPB_W-1:0]  r_rpb;
    logic [RW-1:0]               r_ring;

    // persistent state
    logic [prrp_pkg::OFS_W-1:0]  r_ring_base;
    logic [PG_W:0]               r_last_tail;
    logic [prrp_pkg::CNT_W-1:0]  r_entry_count;

    // block table
    logic [31:0]      mem [NUM_BLOCKS];
    logic [31:0]      r_rd_data;
    logic [BLK_W-1:0] r_clr;
    logic             mem_we;
    logic [BLK_W-1:0] mem_wa;
    logic [31:0]      mem_wd;

    // request working registers
    prrp_pkg::t_state r_state, n_state;
    logic [7:0]       r_blk;
    logic [30:0]      r_want;
    logic [31:0]      r_done;
    logic [PG_W-1:0]  r_prod_lo;
    logic [38:0]      r_seek_mul;
    logic [47:0]      r_seek;
    logic [PG_W-1:0]  r_head;
    logic [CW-1:0]    r_pos;
    logic [RW-1:0]    r_pmod;
    logic             r_second;
    logic [RW:0]      r_cap;
    logic [15:0]      r_cnt;
    logic [32:0]      r_bytes;
    logic [CW-1:0]    r_ds;
    logic [CW-1:0]    r_de;
    logic [CW-1:0]    r_ea;
    logic [PG_W:0]    r_etail;
    logic             r_ovf;

    // shared restoring divider
    logic [CW-1:0]     r_dv_num;
    logic [RW-1:0]     r_dv_den;
    logic [RW-1:0]     r_dv_rem;
    logic [CW-1:0]     r_dv_quo;
    logic [DCNT_W-1:0] r_dv_cnt;
    prrp_pkg::t_state  r_dv_ret;
    logic [RW:0]       dv_trial;
    logic              dv_ge;

    // output register
    logic             r_ovalid;
    prrp_pkg::t_rsp   r_odata;

    // effective configuration values
    logic [prrp_pkg::RLEN_W-1:0] rlen_eff;
    logic [RW-1:0]               wrap_eff;
    logic [PG_W+1:0]             tail_sum;
    logic                        gap_need;
    logic [CW-1:0]               skip_pos;
    logic [RW+1:0]               fit_num;
    logic [CW-1:0]               de_w;
    logic [PG_W:0]               etail_w;
    logic                        accept;
    logic                        out_free;
    logic                        cfg_wr;
    prrp_pkg::t_reg_idx          cfg_idx;

    assign rlen_eff = (r_rlen == '0) ? prrp_pkg::RLEN_W'(1) : r_rlen;
    assign wrap_eff = (r_ring == '0) ? RW'(PAGE_BYTES) : r_ring;
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;

    // divider step
    assign dv_trial = {r_dv_rem, r_dv_num[CW-1]};
    assign dv_ge    = dv_trial >= {1'b0, r_dv_den};

    // tail check on the base position (remainder of ring_base by wrap in r_dv_rem)
    always_comb begin
        logic [PG_W:0] tail_v;
        tail_v   = (r_dv_rem == '0) ? (PG_W+1)'(PAGE_BYTES) : r_last_tail;
        tail_sum = (PG_W+2)'(r_head) + (PG_W+2)'(tail_v);
        gap_need = tail_sum > (PG_W+2)'(PAGE_BYTES);
    end

    // skip to the next wrap, plus a page where the head is unaligned
    always_comb begin
        logic [CW-1:0] adv;
        adv = (r_pmod == '0) ? '0 : CW'(wrap_eff - r_pmod);
        skip_pos = r_pos + adv + ((r_head != '0) ? PAGE_C : '0);
    end

    assign fit_num = (RW+2)'(wrap_eff) - (RW+2)'(r_pmod) + (RW+2)'(r_head);

    // end offset and tail of the chunk
    assign de_w    = r_ds + CW'(r_bytes);
    assign etail_w = (r_de == '0) ? '0 : (PG_W+1)'(((r_de - CW'(1)) & CW'(PG_MASK)) + CW'(1));

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = prrp_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            prrp_pkg::REG_RECORD_LENGTH:     prdata = prrp_pkg::PDATA_W'(r_rlen);
            prrp_pkg::REG_MAX_CHUNK_RECORDS: prdata = prrp_pkg::PDATA_W'(r_maxc);
            prrp_pkg::REG_RECORDS_PER_BLOCK: prdata = prrp_pkg::PDATA_W'(r_rpb);
            prrp_pkg::REG_RING_SIZE:         prdata = prrp_pkg::PDATA_W'(r_ring);
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rlen <= prrp_pkg::RLEN_RST;
            r_maxc <= prrp_pkg::MAXC_RST;
            r_rpb  <= prrp_pkg::RPB_RST;
            r_ring <= prrp_pkg::RING_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                prrp_pkg::REG_RECORD_LENGTH:     r_rlen <= pwdata[prrp_pkg::RLEN_W-1:0];
                prrp_pkg::REG_MAX_CHUNK_RECORDS: r_maxc <= pwdata[prrp_pkg::MAXC_W-1:0];
                prrp_pkg::REG_RECORDS_PER_BLOCK: r_rpb  <= pwdata[prrp_pkg::RPB_W-1:0];
                prrp_pkg::REG_RING_SIZE:         r_ring <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // block table write port: clearing pass or final update
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        if (r_state == prrp_pkg::S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == prrp_pkg::S_OUT && out_free) begin
            mem_we = 1'b1;
            mem_wa = BLK_W'(r_blk);
            mem_wd = r_done + 32'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[BLK_W'(r_blk)];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prrp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            prrp_pkg::S_CLEAR: begin
                if (r_clr == BLK_W'(NUM_BLOCKS - 1)) n_state = prrp_pkg::S_IDLE;
            end
            prrp_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) n_state = prrp_pkg::S_BLK;
            end
            prrp_pkg::S_BLK: begin
                if (16'(r_blk) < 16'(NUM_BLOCKS)) n_state = prrp_pkg::S_RD;
            end
            prrp_pkg::S_RD:   n_state = prrp_pkg::S_LOAD;
            prrp_pkg::S_LOAD: n_state = prrp_pkg::S_HEAD;
            prrp_pkg::S_HEAD: n_state = prrp_pkg::S_DIV;
            prrp_pkg::S_DIV: begin
                if (r_dv_cnt == DCNT_W'(CW - 1)) n_state = r_dv_ret;
            end
            prrp_pkg::S_TAIL: begin
                n_state = gap_need ? prrp_pkg::S_DIV : prrp_pkg::S_FIT;
            end
            prrp_pkg::S_GAP2: begin
                n_state = (r_dv_rem == '0 && r_head != '0) ? prrp_pkg::S_DIV
                                                            : prrp_pkg::S_FIT;
            end
            prrp_pkg::S_PMOD: n_state = prrp_pkg::S_FIT;
            prrp_pkg::S_FIT:  n_state = prrp_pkg::S_DIV;
            prrp_pkg::S_CAP: begin
                if (r_dv_quo != '0 || r_second) begin
                    n_state = prrp_pkg::S_CNT;
                end else if (r_head != '0) begin
                    n_state = prrp_pkg::S_DIV;
                end else begin
                    n_state = prrp_pkg::S_FIT;
                end
            end
            prrp_pkg::S_CNT: n_state = prrp_pkg::S_MUL;
            prrp_pkg::S_MUL: n_state = prrp_pkg::S_DS;
            prrp_pkg::S_DS:  n_state = prrp_pkg::S_DE;
            prrp_pkg::S_DE:  n_state = prrp_pkg::S_EA;
            prrp_pkg::S_EA:  n_state = prrp_pkg::S_OUT;
            prrp_pkg::S_OUT: begin
                if (out_free) n_state = prrp_pkg::S_IDLE;
            end
            default: n_state = prrp_pkg::S_IDLE;
        endcase
    end

    // control registers: clearing counter, divider counter, persistent state, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr         <= '0;
            r_ring_base   <= '0;
            r_last_tail   <= '0;
            r_entry_count <= '0;
            r_ovalid      <= 1'b0;
            r_dv_cnt      <= '0;
        end else begin
            if (r_state == prrp_pkg::S_CLEAR) r_clr <= r_clr + BLK_W'(1);
            if (r_state == prrp_pkg::S_DIV) begin
                r_dv_cnt <= (r_dv_cnt == DCNT_W'(CW - 1)) ? '0 : r_dv_cnt + DCNT_W'(1);
            end
            if (o_rsp.ready) r_ovalid <= 1'b0;
            if (r_state == prrp_pkg::S_OUT && out_free) begin
                r_ovalid      <= 1'b1;
                r_ring_base   <= r_ea[prrp_pkg::OFS_W-1:0];
                r_last_tail   <= r_etail;
                r_entry_count <= r_entry_count + 32'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            prrp_pkg::S_IDLE: begin
                if (accept) begin
                    r_blk    <= i_req.data.block_index;
                    r_want   <= i_req.data.records_wanted;
                    r_second <= 1'b0;
                end
            end
            prrp_pkg::S_BLK: begin
                // index reduction, one subtraction a cycle
                if (16'(r_blk) >= 16'(NUM_BLOCKS)) r_blk <= 8'(16'(r_blk) - 16'(NUM_BLOCKS));
            end
            prrp_pkg::S_LOAD: begin
                r_done     <= r_rd_data;
                r_prod_lo  <= PG_W'(r_rd_data * 32'(rlen_eff));
                r_seek_mul <= 39'(r_blk) * 39'(r_rpb);
            end
            prrp_pkg::S_HEAD: begin
                r_head   <= PG_W'(-r_prod_lo);
                r_seek   <= 48'(r_seek_mul) + 48'(r_done);
                r_pos    <= CW'(r_ring_base);
                r_dv_num <= CW'(r_ring_base);
                r_dv_den <= wrap_eff;
                r_dv_rem <= '0;
                r_dv_ret <= prrp_pkg::S_TAIL;
            end
            prrp_pkg::S_DIV: begin
                r_dv_rem <= dv_ge ? RW'(dv_trial - {1'b0, r_dv_den}) : RW'(dv_trial);
                r_dv_num <= {r_dv_num[CW-2:0], 1'b0};
                r_dv_quo <= {r_dv_quo[CW-2:0], dv_ge};
            end
            prrp_pkg::S_TAIL: begin
                if (gap_need) begin
                    r_pos    <= r_pos + PAGE_C;
                    r_dv_num <= r_pos + PAGE_C;
                    r_dv_rem <= '0;
                    r_dv_ret <= prrp_pkg::S_GAP2;
                end else begin
                    r_pmod <= r_dv_rem;
                end
            end
            prrp_pkg::S_GAP2: begin
                r_pmod <= r_dv_rem;
                if (r_dv_rem == '0 && r_head != '0) begin
                    r_pos    <= r_pos + PAGE_C;
                    r_dv_num <= r_pos + PAGE_C;
                    r_dv_rem <= '0;
                    r_dv_ret <= prrp_pkg::S_PMOD;
                end
            end
            prrp_pkg::S_PMOD: begin
                r_pmod <= r_dv_rem;
            end
            prrp_pkg::S_FIT: begin
                // records that fit before the wrap
                r_dv_num <= CW'(fit_num);
                r_dv_den <= RW'(rlen_eff);
                r_dv_rem <= '0;
                r_dv_ret <= prrp_pkg::S_CAP;
            end
            prrp_pkg::S_CAP: begin
                if (r_dv_quo != '0) begin
                    r_cap <= (RW+1)'(r_dv_quo);
                end else if (r_second) begin
                    r_cap <= (RW+1)'(1);
                end else begin
                    // skip to the next wrap
                    r_second <= 1'b1;
                    r_pos    <= skip_pos;
                    r_pmod   <= '0;
                    r_dv_num <= skip_pos;
                    r_dv_den <= wrap_eff;
                    r_dv_rem <= '0;
                    r_dv_ret <= prrp_pkg::S_PMOD;
                end
            end
            prrp_pkg::S_CNT: begin
                logic [RW:0] c;
                c = r_cap;
                if ((RW+1)'(r_maxc) < c) c = (RW+1)'(r_maxc);
                if ((RW+1)'(r_want) < c) c = (RW+1)'(r_want);
                r_cnt <= c[15:0];
            end
            prrp_pkg::S_MUL: begin
                r_bytes <= 33'(r_cnt) * 33'(rlen_eff);
            end
            prrp_pkg::S_DS: begin
                r_ds  <= r_pos - CW'(r_head);
                r_ovf <= (r_pos < CW'(r_head)) || (r_pos[CW-1:prrp_pkg::OFS_W] != '0);
            end
            prrp_pkg::S_DE: begin
                r_de <= de_w;
            end
            prrp_pkg::S_EA: begin
                // tail of the chunk and the next page boundary after the data
                r_etail <= etail_w;
                r_ea    <= (r_de == '0) ? PAGE_C
                         : (((r_de - CW'(1)) & ~CW'(PG_MASK)) + PAGE_C);
            end
            prrp_pkg::S_OUT: begin
                if (out_free) begin
                    r_odata.entry_id           <= r_entry_count;
                    r_odata.seek_record        <= r_seek;
                    r_odata.chunk_records      <= r_cnt;
                    r_odata.ring_start_aligned <= r_pos[prrp_pkg::OFS_W-1:0];
                    r_odata.data_start         <= r_ds[prrp_pkg::OFS_W-1:0];
                    r_odata.data_end           <= r_de[prrp_pkg::OFS_W-1:0];
                    r_odata.ring_end_aligned   <= r_ea[prrp_pkg::OFS_W-1:0];
                    r_odata.overflow           <= r_ovf
                        || (r_de[CW-1:prrp_pkg::OFS_W] != '0)
                        || (r_ea[CW-1:prrp_pkg::OFS_W] != '0);
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

endmodule

### hw/rtl/prrp_chk.sv
// port-level checker for the ring read planner, bound to the top level
`timescale 1ns / 1ps

module prrp_chk #(
    parameter int PAGE_BYTES = prrp_pkg::PAGE_BYTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [47:0] i_rsp_end,
    input logic [31:0] i_rsp_id,
    input logic        i_pready
);

    localparam int PG_W = $clog2(PAGE_BYTES);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_id))
        else $error("response dropped or changed while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while one is in flight");

    // next base is always page aligned
    a_end_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_end[PG_W-1:0] == '0)
        else $error("ring end offset not page aligned");

    // a response only appears at the end of a request, while the input was closed
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response appeared while idle");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

endmodule

bind page_aligned_ring_read_planner_top prrp_chk #(.PAGE_BYTES(PAGE_BYTES)) u_prrp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_end   (o_rsp.data.ring_end_aligned),
    .i_rsp_id    (o_rsp.data.entry_id),
    .i_pready    (pready)
);
